[design/brmc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit rectangle clip package
// Shared constants and register indexes for the blit rectangle clipper.
// ----------------------------------------------------------------------------
package brmc_pkg;
  localparam int unsigned CoordBitsDef = 16;
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CLIP_MODE = 3'd0,
    CFG_SURF_W    = 3'd1,
    CFG_SURF_H    = 3'd2,
    CFG_VAL_L     = 3'd3,
    CFG_VAL_T     = 3'd4,
    CFG_VAL_R     = 3'd5,
    CFG_VAL_B     = 3'd6,
    CFG_UNUSED    = 3'd7
  } cfg_idx_e;
endpackage

[design/brmc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned quotient, one quotient bit per stage, with a sideband payload.
// ----------------------------------------------------------------------------
module brmc_div
  import brmc_pkg::*;
#(
  parameter int unsigned NumBits = 48,
  parameter int unsigned DenBits = 17,
  parameter int unsigned SideBits = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                vld_i,
  input  logic [NumBits-1:0]  num_i,
  input  logic [DenBits-1:0]  den_i,
  input  logic [SideBits-1:0] side_i,
  output logic                vld_o,
  output logic [NumBits-1:0]  quo_o,
  output logic [SideBits-1:0] side_o
);
  logic                vld_q  [NumBits];
  logic [NumBits-1:0]  num_q  [NumBits];
  logic [DenBits:0]    rem_q  [NumBits];
  logic [DenBits-1:0]  den_q  [NumBits];
  logic [SideBits-1:0] side_q [NumBits];

  for (genvar s = 0; s < NumBits; s++) begin : g_stage
    logic                vld_s;
    logic [NumBits-1:0]  num_s;
    logic [DenBits:0]    rem_s;
    logic [DenBits-1:0]  den_s;
    logic [SideBits-1:0] side_s;
    logic [DenBits+1:0]  trial;
    logic [DenBits+1:0]  diff;
    logic [DenBits:0]    rem_d;
    logic [NumBits-1:0]  num_d;

    if (s == 0) begin : g_first
      assign vld_s  = vld_i;
      assign num_s  = num_i;
      assign rem_s  = '0;
      assign den_s  = den_i;
      assign side_s = side_i;
    end else begin : g_next
      assign vld_s  = vld_q[s-1];
      assign num_s  = num_q[s-1];
      assign rem_s  = rem_q[s-1];
      assign den_s  = den_q[s-1];
      assign side_s = side_q[s-1];
    end

    always_comb begin
      trial = {rem_s, num_s[NumBits-1]};
      diff  = trial - {2'b00, den_s};
      if (trial >= {2'b00, den_s}) begin
        rem_d = diff[DenBits:0];
        num_d = {num_s[NumBits-2:0], 1'b1};
      end else begin
        rem_d = trial[DenBits:0];
        num_d = {num_s[NumBits-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s] <= vld_s;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s]  <= rem_d;
        num_q[s]  <= num_d;
        den_q[s]  <= den_s;
        side_q[s] <= side_s;
      end
    end
  end

  assign vld_o  = vld_q[NumBits-1];
  assign quo_o  = num_q[NumBits-1];
  assign side_o = side_q[NumBits-1];
endmodule

[design/blit_rect_mirror_clip.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit rectangle mirror and clip
// Mirrors and clips a blit source rectangle and rescales the destination.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries one blit request per item;
// output channel out_valid_o/out_ready_i returns one adjusted request.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Stages: mirror and trigger, crop, products, divider operands, four
// parallel pipelined dividers of 2*COORD_BITS+2 stages (one quotient bit
// each), then result assembly. One item enters per cycle while the output
// is not stalled; the divider depth sets the latency.
// The whole pipeline advances as one; when the receiver stalls a full
// output, everything holds and in_ready_o falls. Holes in the pipeline
// stay in place while stalled. Reset empties the pipeline and clears
// the configuration registers.
// ----------------------------------------------------------------------------
module blit_rect_mirror_clip
  import brmc_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CfgIdxBits-1:0]        cfg_idx_i,
  input  logic [COORD_BITS-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] src_x_i,
  input  logic signed [COORD_BITS-1:0] src_y_i,
  input  logic [COORD_BITS-2:0]        src_w_i,
  input  logic [COORD_BITS-2:0]        src_h_i,
  input  logic signed [COORD_BITS-1:0] dst_x_i,
  input  logic signed [COORD_BITS-1:0] dst_y_i,
  input  logic signed [COORD_BITS-1:0] dst_w_i,
  input  logic signed [COORD_BITS-1:0] dst_h_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] out_src_x_o,
  output logic signed [COORD_BITS-1:0] out_src_y_o,
  output logic [COORD_BITS-2:0]        out_src_w_o,
  output logic [COORD_BITS-2:0]        out_src_h_o,
  output logic signed [COORD_BITS-1:0] out_dst_x_o,
  output logic signed [COORD_BITS-1:0] out_dst_y_o,
  output logic [COORD_BITS-2:0]        out_dst_w_o,
  output logic [COORD_BITS-2:0]        out_dst_h_o,
  output logic                         mirror_horizontal_o,
  output logic                         mirror_vertical_o
);
  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned S  = COORD_BITS - 1;
  localparam int unsigned W  = COORD_BITS + 3;   // working width
  localparam int unsigned PW = 2 * W;            // product width
  localparam int unsigned NB = 2 * C + 2;        // divider numerator width
  localparam int unsigned DB = C + 1;            // divider denominator width

  // registers
  logic                cfg_mode_q;
  logic [S-1:0]        cfg_sw_q, cfg_sh_q;
  logic signed [C-1:0] cfg_vl_q, cfg_vt_q, cfg_vr_q, cfg_vb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q <= 1'b0;
      cfg_sw_q   <= '0;
      cfg_sh_q   <= '0;
      cfg_vl_q   <= '0;
      cfg_vt_q   <= '0;
      cfg_vr_q   <= '0;
      cfg_vb_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CLIP_MODE: cfg_mode_q <= cfg_data_i[0];
        CFG_SURF_W:    cfg_sw_q   <= cfg_data_i[S-1:0];
        CFG_SURF_H:    cfg_sh_q   <= cfg_data_i[S-1:0];
        CFG_VAL_L:     cfg_vl_q   <= cfg_data_i;
        CFG_VAL_T:     cfg_vt_q   <= cfg_data_i;
        CFG_VAL_R:     cfg_vr_q   <= cfg_data_i;
        CFG_VAL_B:     cfg_vb_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- stage 1: mirror and clip trigger ----------------
  logic signed [W-1:0] sx_a, sy_a, sw_a, sh_a, dx_a, dy_a, dw_a, dh_a;
  logic signed [W-1:0] bl_a, br_a, bt_a, bb_a, swf, shf, rv, bv;
  logic                mh_a, mv_a, need_a, bemp_a;

  always_comb begin
    sx_a = W'(src_x_i);
    sy_a = W'(src_y_i);
    sw_a = W'(signed'({1'b0, src_w_i}));
    sh_a = W'(signed'({1'b0, src_h_i}));
    dx_a = W'(dst_x_i);
    dy_a = W'(dst_y_i);
    dw_a = W'(dst_w_i);
    dh_a = W'(dst_h_i);
    swf  = W'(signed'({1'b0, cfg_sw_q}));
    shf  = W'(signed'({1'b0, cfg_sh_q}));
    rv   = W'(cfg_vr_q);
    bv   = W'(cfg_vb_q);
    mh_a = 1'b0;
    mv_a = 1'b0;
    if (!cfg_mode_q) begin
      if (dst_w_i < 0) begin
        sx_a = swf - sx_a - sw_a;
        dw_a = -dw_a;
        dx_a = dx_a - (dw_a - W'(1));
        mh_a = 1'b1;
      end
      if (dst_h_i < 0) begin
        sy_a = shf - sy_a - sh_a;
        dh_a = -dh_a;
        dy_a = dy_a - (dh_a - W'(1));
        mv_a = 1'b1;
      end
      bl_a   = '0;
      br_a   = swf - W'(1);
      bt_a   = '0;
      bb_a   = shf - W'(1);
      bemp_a = (cfg_sw_q == '0) || (cfg_sh_q == '0);
      need_a = (sx_a < 0) || (sx_a >= swf) || (sy_a < 0) || (sy_a >= shf) ||
               (sx_a + sw_a > swf) || (sy_a + sh_a > shf);
    end else begin
      need_a = (sx_a < W'(cfg_vl_q)) || (sx_a >= rv) || (sy_a < W'(cfg_vt_q)) ||
               (sy_a >= bv) || (sx_a + sw_a > rv) || (sy_a + sh_a > bv);
      bl_a   = (cfg_vl_q < cfg_vr_q) ? W'(cfg_vl_q) : rv;
      br_a   = (cfg_vl_q < cfg_vr_q) ? rv : W'(cfg_vl_q);
      bt_a   = (cfg_vt_q < cfg_vb_q) ? W'(cfg_vt_q) : bv;
      bb_a   = (cfg_vt_q < cfg_vb_q) ? bv : W'(cfg_vt_q);
      bemp_a = 1'b0;
    end
  end

  logic                v1_q, mh1_q, mv1_q, need1_q, bemp1_q;
  logic signed [W-1:0] sx1_q, sy1_q, sw1_q, sh1_q, dx1_q, dy1_q, dw1_q, dh1_q;
  logic signed [W-1:0] bl1_q, br1_q, bt1_q, bb1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      {sx1_q, sy1_q, sw1_q, sh1_q} <= {sx_a, sy_a, sw_a, sh_a};
      {dx1_q, dy1_q, dw1_q, dh1_q} <= {dx_a, dy_a, dw_a, dh_a};
      {bl1_q, br1_q, bt1_q, bb1_q} <= {bl_a, br_a, bt_a, bb_a};
      {mh1_q, mv1_q, need1_q, bemp1_q} <= {mh_a, mv_a, need_a, bemp_a};
    end
  end

  // ---------------- stage 2: crop ----------------
  logic signed [W-1:0] cl_b, cr_b, ct_b, cb_b, ex_b, ey_b;
  logic                emp_b;

  always_comb begin
    ex_b  = sx1_q + sw1_q - W'(1);
    ey_b  = sy1_q + sh1_q - W'(1);
    cl_b  = (sx1_q > bl1_q) ? sx1_q : bl1_q;
    cr_b  = (ex_b < br1_q) ? ex_b : br1_q;
    ct_b  = (sy1_q > bt1_q) ? sy1_q : bt1_q;
    cb_b  = (ey_b < bb1_q) ? ey_b : bb1_q;
    emp_b = (sw1_q == 0) || (sh1_q == 0) || bemp1_q || (cr_b < cl_b) || (cb_b < ct_b);
  end

  logic                v2_q, mh2_q, mv2_q, need2_q, emp2_q;
  logic signed [W-1:0] sx2_q, sy2_q, sw2_q, sh2_q, dx2_q, dy2_q, dw2_q, dh2_q;
  logic signed [W-1:0] cl2_q, cr2_q, ct2_q, cb2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      {sx2_q, sy2_q, sw2_q, sh2_q} <= {sx1_q, sy1_q, sw1_q, sh1_q};
      {dx2_q, dy2_q, dw2_q, dh2_q} <= {dx1_q, dy1_q, dw1_q, dh1_q};
      {cl2_q, cr2_q, ct2_q, cb2_q} <= {cl_b, cr_b, ct_b, cb_b};
      {mh2_q, mv2_q, need2_q, emp2_q} <= {mh1_q, mv1_q, need1_q, emp_b};
    end
  end

  // ---------------- stage 3: products ----------------
  logic signed [PW-1:0] p_c [4];
  logic signed [W-1:0]  nx_c, ny_c;

  always_comb begin
    nx_c   = dw2_q - W'(1);
    ny_c   = dh2_q - W'(1);
    p_c[0] = PW'(nx_c) * PW'(cl2_q - sx2_q);
    p_c[1] = PW'(nx_c) * PW'(cr2_q - sx2_q);
    p_c[2] = PW'(ny_c) * PW'(ct2_q - sy2_q);
    p_c[3] = PW'(ny_c) * PW'(cb2_q - sy2_q);
  end

  logic                 v3_q, mh3_q, mv3_q, need3_q, emp3_q;
  logic signed [W-1:0]  sx3_q, sy3_q, sw3_q, sh3_q, dx3_q, dy3_q, dw3_q, dh3_q;
  logic signed [W-1:0]  cl3_q, cr3_q, ct3_q, cb3_q;
  logic signed [PW-1:0] p3_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      {sx3_q, sy3_q, sw3_q, sh3_q} <= {sx2_q, sy2_q, sw2_q, sh2_q};
      {dx3_q, dy3_q, dw3_q, dh3_q} <= {dx2_q, dy2_q, dw2_q, dh2_q};
      {cl3_q, cr3_q, ct3_q, cb3_q} <= {cl2_q, cr2_q, ct2_q, cb2_q};
      {mh3_q, mv3_q, need3_q, emp3_q} <= {mh2_q, mv2_q, need2_q, emp2_q};
      for (int i = 0; i < 4; i++) p3_q[i] <= p_c[i];
    end
  end

  // ---------------- stage 4: divider operands ----------------
  logic [NB-1:0] num_d [4];
  logic [DB-1:0] den_d [4];
  logic          zero_d [4];
  logic          neg_d  [4];
  logic signed [PW-1:0] mag_d [4];
  logic signed [W-1:0]  dn_d [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dn_d[i]   = (i < 2) ? (sw3_q - W'(1)) : (sh3_q - W'(1));
      zero_d[i] = (dn_d[i] <= 0);
      neg_d[i]  = p3_q[i] < 0;
      mag_d[i]  = neg_d[i] ? -p3_q[i] : p3_q[i];
      num_d[i]  = NB'(mag_d[i] + mag_d[i] + PW'(dn_d[i]));
      den_d[i]  = zero_d[i] ? DB'(1) : DB'(dn_d[i]);
    end
  end

  logic                 v4_q, mh4_q, mv4_q, need4_q, emp4_q;
  logic signed [W-1:0]  sx4_q, sy4_q, sw4_q, sh4_q, dx4_q, dy4_q, dw4_q, dh4_q;
  logic signed [W-1:0]  cl4_q, cr4_q, ct4_q, cb4_q;
  logic [NB-1:0]        num4_q [4];
  logic [DB-1:0]        den4_q [4];
  logic [1:0]           fl4_q  [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      {sx4_q, sy4_q, sw4_q, sh4_q} <= {sx3_q, sy3_q, sw3_q, sh3_q};
      {dx4_q, dy4_q, dw4_q, dh4_q} <= {dx3_q, dy3_q, dw3_q, dh3_q};
      {cl4_q, cr4_q, ct4_q, cb4_q} <= {cl3_q, cr3_q, ct3_q, cb3_q};
      {mh4_q, mv4_q, need4_q, emp4_q} <= {mh3_q, mv3_q, need3_q, emp3_q};
      for (int i = 0; i < 4; i++) begin
        num4_q[i] <= num_d[i];
        den4_q[i] <= den_d[i];
        fl4_q[i]  <= {zero_d[i], neg_d[i]};
      end
    end
  end

  // ---------------- dividers (quotient = floor(num / 2den)) ----------------
  localparam int unsigned SB = 12 * W + 4;
  logic [SB-1:0] side_in, side_out;
  logic [NB-1:0] quo [4];
  logic [1:0]    fl5 [4];
  logic          v5_all [4];
  logic          v5;

  assign side_in = {sx4_q, sy4_q, sw4_q, sh4_q, dx4_q, dy4_q, dw4_q, dh4_q,
                    cl4_q, cr4_q, ct4_q, cb4_q, mh4_q, mv4_q, need4_q, emp4_q};

  for (genvar i = 0; i < 4; i++) begin : g_div
    if (i == 0) begin : g_main
      logic [SB+1:0] s_o;
      brmc_div #(.NumBits(NB), .DenBits(DB + 1), .SideBits(SB + 2)) u_div (
        .clk_i, .rst_ni, .adv_i(adv), .vld_i(v4_q), .num_i(num4_q[i]),
        .den_i({den4_q[i], 1'b0}), .side_i({fl4_q[i], side_in}),
        .vld_o(v5_all[i]), .quo_o(quo[i]), .side_o(s_o)
      );
      assign side_out = s_o[SB-1:0];
      assign fl5[i]   = s_o[SB+1:SB];
    end else begin : g_aux
      brmc_div #(.NumBits(NB), .DenBits(DB + 1), .SideBits(2)) u_div (
        .clk_i, .rst_ni, .adv_i(adv), .vld_i(v4_q), .num_i(num4_q[i]),
        .den_i({den4_q[i], 1'b0}), .side_i(fl4_q[i]),
        .vld_o(v5_all[i]), .quo_o(quo[i]), .side_o(fl5[i])
      );
    end
  end
  assign v5 = v5_all[0] & v5_all[1] & v5_all[2] & v5_all[3];

  // ---------------- stage 5: assemble ----------------
  logic signed [W-1:0] sx5, sy5, sw5, sh5, dx5, dy5, dw5, dh5, cl5, cr5, ct5, cb5;
  logic                mh5, mv5, need5, emp5;
  logic signed [W-1:0] t_e [4];
  logic signed [W-1:0] osx, osy, osw, osh, odx, ody, odw, odh, x1, x2, y1, y2;

  assign {sx5, sy5, sw5, sh5, dx5, dy5, dw5, dh5, cl5, cr5, ct5, cb5,
          mh5, mv5, need5, emp5} = side_out;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (fl5[i][1]) t_e[i] = '0;
      else if (fl5[i][0]) t_e[i] = -W'(quo[i]);
      else t_e[i] = W'(quo[i]);
    end
    x1 = dx5 + t_e[0];
    x2 = dx5 + t_e[1];
    y1 = dy5 + t_e[2];
    y2 = dy5 + t_e[3];
    {osx, osy, osw, osh, odx, ody, odw, odh} = {sx5, sy5, sw5, sh5, dx5, dy5, dw5, dh5};
    if (need5) begin
      if (emp5) begin
        osw = '0; osh = '0; odw = '0; odh = '0;
      end else begin
        osx = cl5; osy = ct5;
        osw = cr5 - cl5 + W'(1);
        osh = cb5 - ct5 + W'(1);
        odx = x1; ody = y1;
        odw = x2 - x1 + W'(1);
        odh = y2 - y1 + W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= v5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_src_x_o         <= osx[C-1:0];
      out_src_y_o         <= osy[C-1:0];
      out_src_w_o         <= osw[S-1:0];
      out_src_h_o         <= osh[S-1:0];
      out_dst_x_o         <= odx[C-1:0];
      out_dst_y_o         <= ody[C-1:0];
      out_dst_w_o         <= odw[S-1:0];
      out_dst_h_o         <= odh[S-1:0];
      mirror_horizontal_o <= mh5;
      mirror_vertical_o   <= mv5;
    end
  end
endmodule

[design/brmc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit rectangle clip port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module brmc_checker
  import brmc_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [COORD_BITS-2:0] out_src_w_o,
  input logic [COORD_BITS-2:0] out_dst_w_o,
  input logic [COORD_BITS-2:0] out_src_h_o,
  input logic [COORD_BITS-2:0] out_dst_h_o
);
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(out_src_w_o) && $stable(out_src_h_o))
    else $error("stalled item changed");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("ready low with free output");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while stalled");

  a_stall_dst_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_dst_w_o) && $stable(out_dst_h_o))
    else $error("stalled destination size changed");
endmodule

bind blit_rect_mirror_clip brmc_checker #(.COORD_BITS(COORD_BITS)) u_brmc_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i,
  .out_src_w_o, .out_dst_w_o, .out_src_h_o, .out_dst_h_o
);

[verif/blit_rect_mirror_clip_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit rectangle mirror and clip testbench
// Drives blit requests through the valid/ready input channel under random
// bursts and output stalls, predicts each adjusted request in the bench and
// compares it field by field with the returned item, across several clip
// settings written while the block is idle.
// ----------------------------------------------------------------------------
module blit_rect_mirror_clip_test;
  import brmc_pkg::*;

  localparam int CB = 16;
  localparam int SB = CB - 1;
  localparam int LATENCY = 2 * CB + 7;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [CB-1:0] sx, sy;
    logic [SB-1:0] sw, sh;
    logic [CB-1:0] dx, dy, dw, dh;
  } blit_req_t;

  typedef struct packed {
    logic [CB-1:0] sx, sy;
    logic [SB-1:0] sw, sh;
    logic [CB-1:0] dx, dy;
    logic [SB-1:0] dw, dh;
    logic          mh, mv;
  } blit_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [CB-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  blit_req_t req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  wire blit_res_t res;

  logic            mode_q;
  longint          surf_w_q, surf_h_q, vl_q, vt_q, vr_q, vb_q;
  blit_res_t       adjusted_q[$];
  int              errors = 0;
  longint          cycles = 0;
  int              hold_off = 0;
  bit              stall_en = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  blit_rect_mirror_clip dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .src_x_i(req.sx), .src_y_i(req.sy), .src_w_i(req.sw), .src_h_i(req.sh),
    .dst_x_i(req.dx), .dst_y_i(req.dy), .dst_w_i(req.dw), .dst_h_i(req.dh),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_src_x_o(res.sx), .out_src_y_o(res.sy),
    .out_src_w_o(res.sw), .out_src_h_o(res.sh),
    .out_dst_x_o(res.dx), .out_dst_y_o(res.dy),
    .out_dst_w_o(res.dw), .out_dst_h_o(res.dh),
    .mirror_horizontal_o(res.mh), .mirror_vertical_o(res.mv)
  );

  function automatic longint scaled(longint num, longint den, longint d);
    longint p, mag, q;
    if (den <= 0) return 0;
    p = num * d;
    mag = p < 0 ? -p : p;
    q = (2 * mag + den) / (2 * den);
    return p < 0 ? -q : q;
  endfunction

  function automatic blit_res_t adjust_blit(blit_req_t r);
    longint sx, sy, sw, sh, dx, dy, dw, dh, bl, br, bt, bb;
    longint cl, cr, ct, cbt, x1, x2, y1, y2;
    bit mh, mv, empty_bound, need;
    blit_res_t o;
    sx = $signed(r.sx); sy = $signed(r.sy); sw = r.sw; sh = r.sh;
    dx = $signed(r.dx); dy = $signed(r.dy); dw = $signed(r.dw); dh = $signed(r.dh);
    mh = 0; mv = 0;
    if (!mode_q) begin
      if (dw < 0) begin
        sx = surf_w_q - sx - sw; dw = -dw; dx -= dw - 1; mh = 1;
      end
      if (dh < 0) begin
        sy = surf_h_q - sy - sh; dh = -dh; dy -= dh - 1; mv = 1;
      end
      bl = 0; br = surf_w_q - 1; bt = 0; bb = surf_h_q - 1;
      empty_bound = surf_w_q == 0 || surf_h_q == 0;
      need = sx < 0 || sx >= surf_w_q || sy < 0 || sy >= surf_h_q ||
             sx + sw > surf_w_q || sy + sh > surf_h_q;
    end else begin
      need = sx < vl_q || sx >= vr_q || sy < vt_q || sy >= vb_q ||
             sx + sw > vr_q || sy + sh > vb_q;
      bl = vl_q < vr_q ? vl_q : vr_q; br = vl_q < vr_q ? vr_q : vl_q;
      bt = vt_q < vb_q ? vt_q : vb_q; bb = vt_q < vb_q ? vb_q : vt_q;
      empty_bound = 0;
    end
    if (need) begin
      cl = sx > bl ? sx : bl; cr = (sx + sw - 1) < br ? sx + sw - 1 : br;
      ct = sy > bt ? sy : bt; cbt = (sy + sh - 1) < bb ? sy + sh - 1 : bb;
      if (sw == 0 || sh == 0 || empty_bound || cr < cl || cbt < ct) begin
        sw = 0; sh = 0; dw = 0; dh = 0;
      end else begin
        x1 = dx + scaled(dw - 1, sw - 1, cl - sx);
        x2 = dx + scaled(dw - 1, sw - 1, cr - sx);
        y1 = dy + scaled(dh - 1, sh - 1, ct - sy);
        y2 = dy + scaled(dh - 1, sh - 1, cbt - sy);
        sx = cl; sy = ct; sw = cr - cl + 1; sh = cbt - ct + 1;
        dx = x1; dy = y1; dw = x2 - x1 + 1; dh = y2 - y1 + 1;
      end
    end
    o.sx = sx[CB-1:0]; o.sy = sy[CB-1:0]; o.sw = sw[SB-1:0]; o.sh = sh[SB-1:0];
    o.dx = dx[CB-1:0]; o.dy = dy[CB-1:0]; o.dw = dw[SB-1:0]; o.dh = dh[SB-1:0];
    o.mh = mh; o.mv = mv;
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[blit_rect_mirror_clip] ERROR");
      $finish;
    end
  end

  // receiver: stall pattern plus optional long hold-off
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (!stall_en) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 9) < 7) || (cycles % 300 < 60);
  end

  always @(posedge clk) begin
    blit_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (adjusted_q.size() == 0) begin
        $display("%0t unexpected item: expected none actual %h", $time, res);
        errors++;
      end else begin
        want = adjusted_q.pop_front();
        if (want.sx !== res.sx) begin
          $display("%0t src_x exp %h act %h", $time, want.sx, res.sx); errors++; end
        if (want.sy !== res.sy) begin
          $display("%0t src_y exp %h act %h", $time, want.sy, res.sy); errors++; end
        if (want.sw !== res.sw) begin
          $display("%0t src_w exp %h act %h", $time, want.sw, res.sw); errors++; end
        if (want.sh !== res.sh) begin
          $display("%0t src_h exp %h act %h", $time, want.sh, res.sh); errors++; end
        if (want.dx !== res.dx) begin
          $display("%0t dst_x exp %h act %h", $time, want.dx, res.dx); errors++; end
        if (want.dy !== res.dy) begin
          $display("%0t dst_y exp %h act %h", $time, want.dy, res.dy); errors++; end
        if (want.dw !== res.dw) begin
          $display("%0t dst_w exp %h act %h", $time, want.dw, res.dw); errors++; end
        if (want.dh !== res.dh) begin
          $display("%0t dst_h exp %h act %h", $time, want.dh, res.dh); errors++; end
        if (want.mh !== res.mh) begin
          $display("%0t mirror_h exp %b act %b", $time, want.mh, res.mh); errors++; end
        if (want.mv !== res.mv) begin
          $display("%0t mirror_v exp %b act %b", $time, want.mv, res.mv); errors++; end
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, longint value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value[CB-1:0];
    case (idx)
      CFG_CLIP_MODE: mode_q = value[0];
      CFG_SURF_W:    surf_w_q = value[SB-1:0];
      CFG_SURF_H:    surf_h_q = value[SB-1:0];
      CFG_VAL_L:     vl_q = $signed(value[CB-1:0]);
      CFG_VAL_T:     vt_q = $signed(value[CB-1:0]);
      CFG_VAL_R:     vr_q = $signed(value[CB-1:0]);
      CFG_VAL_B:     vb_q = $signed(value[CB-1:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup(bit m, longint w, longint h, longint l, longint t,
                       longint r, longint b);
    write_reg(CFG_CLIP_MODE, m);
    write_reg(CFG_SURF_W, w);
    write_reg(CFG_SURF_H, h);
    write_reg(CFG_VAL_L, l);
    write_reg(CFG_VAL_T, t);
    write_reg(CFG_VAL_R, r);
    write_reg(CFG_VAL_B, b);
  endtask

  // sends one item; valid is held until accepted
  task automatic send_blit(blit_req_t r);
    adjusted_q.push_back(adjust_blit(r));
    in_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (adjusted_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic blit_req_t mk(int sx, int sy, int sw, int sh,
                                   int dx, int dy, int dw, int dh);
    blit_req_t r;
    r.sx = CB'(sx); r.sy = CB'(sy); r.sw = SB'(sw); r.sh = SB'(sh);
    r.dx = CB'(dx); r.dy = CB'(dy); r.dw = CB'(dw); r.dh = CB'(dh);
    return r;
  endfunction

  function automatic int near_coord(longint span);
    if ($urandom_range(0, 7) == 0) return $urandom();
    return $urandom_range(0, 2 * span + 40) - 20 - span / 2;
  endfunction

  function automatic blit_req_t rand_blit(longint span);
    blit_req_t r;
    if ($urandom_range(0, 9) == 0) begin
      return blit_req_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    end
    r.sx = CB'(near_coord(span)); r.sy = CB'(near_coord(span));
    r.sw = SB'(($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, span + 10));
    r.sh = SB'(($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, span + 10));
    r.dx = CB'(near_coord(span)); r.dy = CB'(near_coord(span));
    r.dw = CB'(($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 200) - 100);
    r.dh = CB'(($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 200) - 100);
    return r;
  endfunction

  task automatic random_burst(int n, longint span);
    int left;
    left = n;
    while (left > 0) begin
      repeat ($urandom_range(1, 20)) begin
        if (left > 0) begin
          send_blit(rand_blit(span));
          left--;
        end
      end
      if ($urandom_range(0, 2) != 0) idle_gap();
    end
  endtask

  task automatic test_directed_surface();
    setup(0, 100, 80, 0, 0, 0, 0);
    send_blit(mk(10, 10, 20, 20, 0, 0, 20, 20));
    send_blit(mk(-5, -5, 20, 20, 0, 0, 40, 40));
    send_blit(mk(90, 70, 20, 20, 5, 5, -40, -10));
    send_blit(mk(10, 10, 20, 20, 0, 0, -20, 20));
    send_blit(mk(10, 10, 20, 20, 0, 0, 20, -20));
    send_blit(mk(200, 10, 5, 5, 0, 0, 5, 5));
    send_blit(mk(10, 10, 0, 5, 0, 0, 5, 5));
    send_blit(mk(-1, 5, 1, 1, 0, 0, 9, 9));
    send_blit(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_blit(mk(-32768, -32768, 32767, 32767, -32768, -32768, -32768, -32768));
    send_blit(mk(0, 0, 0, 0, 0, 0, 0, 0));
    send_blit(mk(-1, -1, 3, 3, -1, -1, -1, -1));
    drain();
    setup(0, 0, 0, 0, 0, 0, 0);
    send_blit(mk(0, 0, 5, 5, 0, 0, 5, 5));
    send_blit(mk(0, 0, 5, 5, 0, 0, -5, -5));
    drain();
  endtask

  task automatic test_directed_valid();
    setup(1, 32767, 32767, 10, 10, 50, 40);
    send_blit(mk(20, 20, 10, 10, 0, 0, 10, 10));
    send_blit(mk(5, 5, 50, 50, 0, 0, 100, 100));
    send_blit(mk(5, 5, 50, 50, 0, 0, -100, -30));
    send_blit(mk(45, 15, 6, 6, 3, 3, 7, 7));
    send_blit(mk(100, 100, 5, 5, 0, 0, 5, 5));
    drain();
    setup(1, 0, 0, 50, 40, 10, 10);
    send_blit(mk(5, 5, 50, 50, 0, 0, 30, 30));
    send_blit(mk(20, 20, 5, 5, 0, 0, 9, 9));
    drain();
    setup(1, 0, 0, -32768, -32768, 32767, 32767);
    send_blit(mk(-32768, -32768, 32767, 32767, 1, 1, 32767, -32768));
    drain();
  endtask

  task automatic test_random_configs();
    longint w, h;
    for (int k = 0; k < 12; k++) begin
      w = (k % 4 == 3) ? $urandom_range(0, 32767) : $urandom_range(0, 120);
      h = (k % 4 == 3) ? $urandom_range(0, 32767) : $urandom_range(0, 120);
      setup(k[0], w, h, $urandom_range(0, 160) - 60, $urandom_range(0, 160) - 60,
            $urandom_range(0, 160) - 60, $urandom_range(0, 160) - 60);
      random_burst(130, 120);
      drain();
    end
  endtask

  task automatic test_backpressure();
    setup(0, 64, 64, 0, 0, 0, 0);
    hold_off = 300;
    random_burst(120, 64);
    drain();
    stall_en = 1'b0;
    random_burst(100, 64);
    drain();
    stall_en = 1'b1;
  endtask

  initial begin
    mode_q = 0; surf_w_q = 0; surf_h_q = 0;
    vl_q = 0; vt_q = 0; vr_q = 0; vb_q = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_blit(mk(3, 3, 2, 2, 0, 0, -2, 2));
    drain();
    test_directed_surface();
    test_directed_valid();
    test_random_configs();
    test_backpressure();
    if (errors == 0) $display("[blit_rect_mirror_clip] OK");
    else $display("[blit_rect_mirror_clip] ERROR");
    $finish;
  end
endmodule
